// File: rtl/core/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg: shared definitions for the URL percent decoder
// Character codes, escape phase type and the hex digit helper.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    // Escape progress: nothing held, a '%' held, a '%' and the high digit held.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HIGH = 2'd2
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_nibble;

    // Value of an ASCII hex digit in either case, with a flag telling
    // whether the byte is a hex digit at all.
    function automatic t_nibble hex_nibble(input logic [7:0] b);
        t_nibble    res;
        logic [7:0] diff;
        res  = '{ok: 1'b0, value: 4'd0};
        diff = 8'd0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            diff = b - CH_ZERO;
            res  = '{ok: 1'b1, value: diff[3:0]};
        end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
            diff = b - CH_LOWER_A + HEX_TEN;
            res  = '{ok: 1'b1, value: diff[3:0]};
        end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
            diff = b - CH_UPPER_A + HEX_TEN;
            res  = '{ok: 1'b1, value: diff[3:0]};
        end
        return res;
    endfunction

endpackage

// File: rtl/core/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder: form-style URL percent decoder
// Decodes %XX escapes and '+' into bytes, one encoded word per cycle unless the result buffer backs up.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel (i_in_valid / o_in_ready) carries one encoded byte per
// word, with i_in_final set on the last byte of a string. The output channel
// (o_out_valid / i_out_ready) carries decoded bytes. o_out_run_end marks the
// last output word caused by one input word, and o_out_string_end marks the
// last decoded byte of a string.
// Each accepted input word is decoded in the cycle it is accepted and its
// results, zero to three bytes, land in a small result buffer. The first
// result is visible in the cycle after acceptance. Words that yield one
// result stream at one per cycle while the receiver is ready, since a new
// input is taken in the same cycle the last buffered result is taken. A word
// that yields two or three results (a broken escape, or a flush at the
// string end) holds the input side while the buffer drains. Escape openers
// that yield nothing are accepted every cycle.
// Reset clears the buffer and any held escape. When the receiver stalls,
// the current result is held and the input side stops while any result of
// the previous word is still waiting to be taken.
// ----------------------------------------------------------------------------
module url_percent_decoder
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_final,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_run_end,
    output logic       o_out_string_end
);

    // Escape state.
    t_phase     r_phase, n_phase;
    logic [7:0] r_high, n_high;

    // Result buffer: up to three bytes, a read index and a count left.
    logic [7:0] r_buf [3];
    logic [7:0] n_buf [3];
    logic [1:0] r_left, n_count;
    logic [1:0] r_idx;
    logic       r_fin;

    logic       accept;
    logic       pop;
    logic       last;

    // Fresh decode of the incoming byte, as if nothing were held.
    logic       fr_emit;
    logic       fr_hold;
    logic [7:0] fr_byte;
    t_nibble    in_nib;
    t_nibble    high_nib;

    assign last        = (r_left == 2'd1);
    assign o_out_valid = (r_left != 2'd0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_left == 2'd0) || (last && i_out_ready);
    assign accept      = i_in_valid && o_in_ready;

    assign in_nib   = hex_nibble(i_in_byte);
    assign high_nib = hex_nibble(r_high);
    assign fr_hold  = (i_in_byte == CH_PERCENT) && !i_in_final;
    assign fr_emit  = !fr_hold;
    assign fr_byte  = (i_in_byte == CH_PLUS) ? CH_SPACE : i_in_byte;

    // Next escape state.
    always_comb begin
        n_phase = r_phase;
        n_high  = r_high;
        unique case (r_phase)
            PH_PCT: begin
                if (in_nib.ok && !i_in_final) begin
                    n_phase = PH_HIGH;
                    n_high  = i_in_byte;
                end else begin
                    n_phase = (fr_hold && !in_nib.ok) ? PH_PCT : PH_IDLE;
                end
            end
            PH_HIGH: begin
                n_phase = (!in_nib.ok && fr_hold) ? PH_PCT : PH_IDLE;
            end
            default: begin
                n_phase = fr_hold ? PH_PCT : PH_IDLE;
            end
        endcase
        if (i_in_final) begin
            n_phase = PH_IDLE;
            n_high  = 8'd0;
        end
    end

    // Result bytes produced by the incoming word.
    always_comb begin
        n_buf[0] = fr_byte;
        n_buf[1] = fr_byte;
        n_buf[2] = fr_byte;
        n_count  = {1'b0, fr_emit};
        unique case (r_phase)
            PH_PCT: begin
                n_buf[0] = CH_PERCENT;
                if (in_nib.ok) begin
                    n_buf[1] = i_in_byte;
                    n_count  = i_in_final ? 2'd2 : 2'd0;
                end else begin
                    n_count = fr_emit ? 2'd2 : 2'd1;
                end
            end
            PH_HIGH: begin
                if (in_nib.ok) begin
                    n_buf[0] = {high_nib.value, in_nib.value};
                    n_count  = 2'd1;
                end else begin
                    n_buf[0] = CH_PERCENT;
                    n_buf[1] = r_high;
                    n_count  = fr_emit ? 2'd3 : 2'd2;
                end
            end
            default: begin
                n_buf[0] = fr_byte;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_high  <= 8'd0;
            r_left  <= 2'd0;
            r_idx   <= 2'd0;
            r_fin   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_left  <= n_count;
            r_idx   <= 2'd0;
            r_fin   <= i_in_final;
        end else if (pop) begin
            r_left <= r_left - 2'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf[0] <= n_buf[0];
            r_buf[1] <= n_buf[1];
            r_buf[2] <= n_buf[2];
        end
    end

    always_comb begin
        unique case (r_idx)
            2'd1:    o_out_byte = r_buf[1];
            2'd2:    o_out_byte = r_buf[2];
            default: o_out_byte = r_buf[0];
        endcase
    end

    assign o_out_run_end    = last;
    assign o_out_string_end = last && r_fin;

    // A final word always yields at least one result.
    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_final |=> o_out_valid)
        else $error("final word produced no result");

    // No escape survives the end of a string.
    a_final_clears_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_final |=> r_phase == PH_IDLE)
        else $error("escape held across string end");

    // While results are buffered, input is only taken when the last one is shown.
    a_ready_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_out_run_end)
        else $error("input accepted with results still buffered");

    a_string_end_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_string_end |-> o_out_run_end)
        else $error("string end without run end");

endmodule
